@@ sv/plsa_pkg.sv @@
package plsa_pkg;

  localparam int unsigned CAP_W = 22;

  localparam logic [3:0]       CRIT_PRIO = 4'd10;
  localparam logic [3:0]       MIN_PRIO  = 4'd1;
  localparam logic [CAP_W-1:0] CAP_RESET = 22'd5000;
  localparam logic [CAP_W-1:0] W22_MAX   = 22'h3F_FFFF;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TOGGLE   = 1'b1;

  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_ON         = 3'd1;
  localparam logic [2:0] ST_OFF        = 3'd2;
  localparam logic [2:0] ST_REFUSED    = 3'd3;
  localparam logic [2:0] ST_SHED_ON    = 3'd4;
  localparam logic [2:0] ST_SHED_FAIL  = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;

  typedef struct packed {
    logic        op;
    logic [5:0]  slot;
    logic [15:0] rate;
    logic        critical;
    logic [3:0]  priority_req;
  } plsa_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [63:0]      shed_mask;
    logic [CAP_W-1:0] freed_watts;
    logic [CAP_W-1:0] total_load;
  } plsa_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LATCH,
    S_EVAL,
    S_SCAN,
    S_ADMIT,
    S_FIN
  } plsa_state_t;

  typedef struct packed {
    logic       load;
    logic       reg_wr;
    logic       turn_off;
    logic       turn_on;
    logic       need_ld;
    logic       scan_init;
    logic       scan_run;
    logic       status_we;
    logic [2:0] status_code;
    logic       out_load;
  } plsa_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_reg;
    logic valid;
    logic on;
    logic fits;
    logic critical;
    logic zero_need;
    logic scan_end;
    logic enough;
    logic out_free;
  } plsa_stat_t;

endpackage

@@ sv/plsa_ctrl.sv @@
module plsa_ctrl
  import plsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  plsa_stat_t stat,
  output plsa_cmd_t  cmd
);

  plsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        cmd.need_ld = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        cmd.status_we = 1'b1;
        state_nxt     = S_FIN;
        priority if (!stat.in_range) begin
          cmd.status_code = ST_EMPTY;
        end else if (stat.is_reg) begin
          cmd.reg_wr      = 1'b1;
          cmd.status_code = ST_REGISTERED;
        end else if (!stat.valid) begin
          cmd.status_code = ST_EMPTY;
        end else if (stat.on) begin
          cmd.turn_off    = 1'b1;
          cmd.status_code = ST_OFF;
        end else if (stat.fits) begin
          cmd.turn_on     = 1'b1;
          cmd.status_code = ST_ON;
        end else if (!stat.critical) begin
          cmd.status_code = ST_REFUSED;
        end else if (stat.zero_need) begin
          cmd.turn_on     = 1'b1;
          cmd.status_code = ST_SHED_ON;
        end else begin
          cmd.status_we = 1'b0;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_ADMIT;
        end
      end
      S_ADMIT: begin
        cmd.status_we = 1'b1;
        state_nxt     = S_FIN;
        if (stat.enough) begin
          cmd.turn_on     = 1'b1;
          cmd.status_code = ST_SHED_ON;
        end else begin
          cmd.status_code = ST_SHED_FAIL;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ sv/plsa_dp.sv @@
module plsa_dp
  import plsa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  plsa_in_t         in_data,
  input  logic             out_stall,
  output logic             out_valid,
  output plsa_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  plsa_cmd_t        cmd,
  output plsa_stat_t       stat
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = (SW + 17 > CAP_W + 1) ? SW + 17 : CAP_W + 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  logic [15:0] mem_rate [SLOTS];
  logic [3:0]  mem_prio [SLOTS];
  logic        mem_crit [SLOTS];

  plsa_in_t         req_r;
  logic [CAP_W-1:0] cap_r;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] on_r, on_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic [TW-1:0]    freed_r, freed_nxt;
  logic [63:0]      mask_r, mask_nxt;
  logic [15:0]      need_r;
  logic             crit_r;
  logic [2:0]       status_r;

  logic [15:0]      rd_rate_r;
  logic [3:0]       rd_prio_r;
  logic             rd_crit_r;
  logic [SW-1:0]    rd_idx_r;
  logic [3:0]       rd_p_r;
  logic             rd_last_r;
  logic             rv_r;

  logic [SW-1:0]    scan_i_r;
  logic [3:0]       scan_p_r;
  logic             issue_done_r;

  plsa_out_t        out_r;
  logic             out_valid_r;

  logic [SW-1:0]    slot_idx;
  logic [SW-1:0]    rd_addr;
  logic [3:0]       prio_store;
  logic             hit;
  logic             scan_last;

  assign slot_idx  = SW'(req_r.slot);
  assign rd_addr   = cmd.scan_run ? scan_i_r : slot_idx;
  assign scan_last = (scan_i_r == LAST_IDX) && (scan_p_r == CRIT_PRIO);

  always_comb begin
    if (req_r.critical) begin
      prio_store = CRIT_PRIO;
    end else if (req_r.priority_req < MIN_PRIO) begin
      prio_store = MIN_PRIO;
    end else if (req_r.priority_req > CRIT_PRIO) begin
      prio_store = CRIT_PRIO;
    end else begin
      prio_store = req_r.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reg_wr) begin
      mem_rate[slot_idx] <= req_r.rate;
      mem_prio[slot_idx] <= prio_store;
      mem_crit[slot_idx] <= req_r.critical;
    end
    rd_rate_r <= mem_rate[rd_addr];
    rd_prio_r <= mem_prio[rd_addr];
    rd_crit_r <= mem_crit[rd_addr];
  end

  // Shed a non-critical on load whose priority matches this pass.
  assign hit = cmd.scan_run && rv_r && valid_r[rd_idx_r] && on_r[rd_idx_r] &&
               !rd_crit_r && (rd_prio_r == rd_p_r);

  always_comb begin
    valid_nxt = valid_r;
    on_nxt    = on_r;
    total_nxt = total_r;
    freed_nxt = freed_r;
    mask_nxt  = mask_r;
    if (cmd.load) begin
      freed_nxt = '0;
      mask_nxt  = '0;
    end
    if (cmd.reg_wr) begin
      if (valid_r[slot_idx] && on_r[slot_idx]) begin
        total_nxt = total_r - TW'(need_r);
      end
      valid_nxt[slot_idx] = 1'b1;
      on_nxt[slot_idx]    = 1'b0;
    end
    if (cmd.turn_off) begin
      on_nxt[slot_idx] = 1'b0;
      total_nxt        = total_r - TW'(need_r);
    end
    if (cmd.turn_on) begin
      on_nxt[slot_idx] = 1'b1;
      total_nxt        = total_r + TW'(need_r);
    end
    if (hit) begin
      on_nxt[rd_idx_r] = 1'b0;
      total_nxt        = total_r - TW'(rd_rate_r);
      freed_nxt        = freed_r + TW'(rd_rate_r);
      for (int k = 0; k < 64; k++) begin
        if (k < SLOTS && 32'(rd_idx_r) == k) begin
          mask_nxt[k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      on_r         <= '0;
      total_r      <= '0;
      cap_r        <= CAP_RESET;
      rv_r         <= 1'b0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      on_r    <= on_nxt;
      total_r <= total_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.scan_init) begin
        rv_r         <= 1'b0;
        issue_done_r <= 1'b0;
      end else if (cmd.scan_run) begin
        rv_r <= !issue_done_r;
        if (!issue_done_r && scan_last) begin
          issue_done_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    freed_r <= freed_nxt;
    mask_r  <= mask_nxt;
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.need_ld) begin
      need_r <= rd_rate_r;
      crit_r <= rd_crit_r;
    end
    if (cmd.status_we) begin
      status_r <= cmd.status_code;
    end
    if (cmd.scan_init) begin
      scan_i_r <= '0;
      scan_p_r <= MIN_PRIO;
    end else if (cmd.scan_run && !issue_done_r) begin
      rd_idx_r  <= scan_i_r;
      rd_p_r    <= scan_p_r;
      rd_last_r <= scan_last;
      if (scan_i_r == LAST_IDX) begin
        scan_i_r <= '0;
        scan_p_r <= scan_p_r + 4'd1;
      end else begin
        scan_i_r <= scan_i_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_r.status      <= status_r;
      out_r.shed_mask   <= mask_r;
      out_r.freed_watts <= (freed_r > TW'(W22_MAX)) ? W22_MAX : freed_r[CAP_W-1:0];
      out_r.total_load  <= (total_r > TW'(W22_MAX)) ? W22_MAX : total_r[CAP_W-1:0];
    end
  end

  always_comb begin
    stat           = '0;
    stat.in_range  = (32'(req_r.slot) < SLOTS);
    stat.is_reg    = (req_r.op == OP_REGISTER);
    stat.valid     = valid_r[slot_idx];
    stat.on        = on_r[slot_idx];
    stat.fits      = ((total_r + TW'(need_r)) <= TW'(cap_r));
    stat.critical  = crit_r;
    stat.zero_need = (need_r == 16'd0);
    stat.scan_end  = (freed_nxt >= TW'(need_r)) || (rv_r && rd_last_r);
    stat.enough    = (freed_r >= TW'(need_r));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_on_from_off: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.turn_on |-> !on_r[slot_idx])
    else $error("admitting a load that is already on");

  a_no_overshed: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (freed_r < TW'(need_r)))
    else $error("shedding continued after enough watts were freed");

  a_reg_off: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reg_wr |=> valid_r[$past(slot_idx)] && !on_r[$past(slot_idx)])
    else $error("registered slot not valid and off");

endmodule

@@ sv/priority_load_shedding_admission.sv @@
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_data  (plsa_in_t)
// out      output     out_valid/out_stall out_data (plsa_out_t)
// cfg      input      cfg_we              cfg_wdata (max_capacity)
//
// Register and toggle without shedding pass through READ, LATCH, EVAL and FIN.
// A shedding toggle adds the SCAN and ADMIT states: the scan reads the load
// table memory one slot per cycle for each priority 1..10, stopping early.
// One transaction is in flight; in_stall is high until its result is loaded.
// rst_n (synchronous) clears all slots to empty and max_capacity to 5000.
// A stalled result holds in the output register while the next input is taken.
module priority_load_shedding_admission
  import plsa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  plsa_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output plsa_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  plsa_cmd_t  cmd;
  plsa_stat_t stat;

  plsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  plsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
